### rtl/rmxt_pkg.sv
`timescale 1ns / 1ps

package rmxt_pkg;

  localparam int MaxItems  = 1024;
  localparam int ValueBits = 32;

  // Fixed field widths of the ports
  localparam int DataW   = 32;
  localparam int PosW    = 11;
  localparam int ModeW   = 2;
  localparam int StatusW = 2;

  // Storage geometry: null node 0 plus, for each append, a root node and one node per bit level
  localparam int NodeDepth = 1 + MaxItems * (ValueBits + 1);
  localparam int NodeW     = $clog2(NodeDepth);
  localparam int RootDepth = MaxItems + 1;
  localparam int ItemW     = $clog2(RootDepth);
  localparam int CntW      = $clog2(MaxItems + 1);
  localparam int BitIdxW   = (ValueBits > 1) ? $clog2(ValueBits) : 1;

  typedef enum logic [ModeW-1:0] {
    MODE_APPEND = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  // Node entry: both children and the count of each child
  typedef struct packed {
    logic [NodeW-1:0] child_zero;
    logic [NodeW-1:0] child_one;
    logic [CntW-1:0]  count_zero;
    logic [CntW-1:0]  count_one;
  } node_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROOT = 4'b0010,
    ST_WALK = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

endpackage

### rtl/range_max_xor_trie_unit.sv
`timescale 1ns / 1ps

// Versioned binary trie answering range max-XOR queries.
// Input channel (in_valid_i/in_ready_o) carries one request: mode_i selects
// append of data_value_i, a query over appended positions range_first_i to
// range_last_i (1-based, inclusive) with key data_value_i, or clear.
// Output channel (out_valid_o/out_ready_i) returns exactly one result per
// request: max_xor_o and status_o.
// One request is processed at a time; in_ready_o is high only when idle.
// Append and query go from acceptance through the version root memory
// read (ST_ROOT), then one bit level per ST_WALK step through the node
// memory (one synchronous read per level), then the output load in
// ST_FIN. Clear, full-store appends, bad ranges and unused modes go
// straight to ST_FIN for the output load. in_ready_o rises together with
// out_valid_o, when the result is loaded. The finished result sits in an
// output register; if the receiver stalls, the block still takes and
// processes the next request, then holds that result in ST_FIN until the
// output register is free.
// Reset empties the store (no versions, no nodes) at once; the memories
// need no clearing pass since node 0 and version 0 are decoded as null.
module range_max_xor_trie_unit
  import rmxt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ModeW-1:0]   mode_i,
  input  logic [DataW-1:0]   data_value_i,
  input  logic [PosW-1:0]    range_first_i,
  input  logic [PosW-1:0]    range_last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DataW-1:0]   max_xor_o,
  output logic [StatusW-1:0] status_o
);

  // Memories
  node_t            node_mem [NodeDepth];
  logic [NodeW-1:0] root_mem [RootDepth];

  // Control state
  state_e            state_q, state_d;
  logic              is_query_q, is_query_d;
  logic [ItemW-1:0]  items_q, items_d;
  logic [NodeW-1:0]  nodes_q, nodes_d;
  logic              out_valid_q, out_valid_d;
  logic [BitIdxW-1:0] bit_q, bit_d;

  // Payload state
  logic [ValueBits-1:0] data_q, data_d;
  logic [NodeW-1:0]     cur_q, cur_d;
  logic [ValueBits-1:0] acc_q, acc_d;
  logic [StatusW-1:0]   res_status_q, res_status_d;
  logic [DataW-1:0]     max_xor_q, max_xor_d;
  logic [StatusW-1:0]   status_q, status_d;

  // Memory ports
  logic              root_we;
  logic [ItemW-1:0]  root_waddr;
  logic [NodeW-1:0]  root_wdata;
  logic [ItemW-1:0]  root_ra_a, root_ra_b;
  logic [NodeW-1:0]  root_rd_a_q, root_rd_b_q;
  logic              root_null_a_q, root_null_b_q;
  logic [NodeW-1:0]  root_a, root_b;

  logic              node_we;
  logic [NodeW-1:0]  node_waddr;
  node_t             node_wdata;
  logic [NodeW-1:0]  node_ra_a, node_ra_b;
  node_t             node_rd_a_q, node_rd_b_q;
  logic              node_null_a_q, node_null_b_q;
  node_t             ent_a, ent_b;

  // Walk helpers
  logic              key_bit;
  logic [NodeW-1:0]  fresh;
  logic [CntW-1:0]   hi_opp_cnt, lo_opp_cnt;
  logic              take;
  logic              last_level;
  logic              range_ok;
  logic              in_acc;
  logic              out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign max_xor_o   = max_xor_q;
  assign status_o    = status_q;

  // Version 0 and node 0 are the empty tree
  assign root_a = root_null_a_q ? '0 : root_rd_a_q;
  assign root_b = root_null_b_q ? '0 : root_rd_b_q;
  assign ent_a  = node_null_a_q ? '0 : node_rd_a_q;
  assign ent_b  = node_null_b_q ? '0 : node_rd_b_q;

  assign key_bit    = data_q[bit_q];
  assign fresh      = cur_q + NodeW'(1);
  assign hi_opp_cnt = key_bit ? ent_a.count_zero : ent_a.count_one;
  assign lo_opp_cnt = key_bit ? ent_b.count_zero : ent_b.count_one;
  assign take       = hi_opp_cnt > lo_opp_cnt;
  assign last_level = (bit_q == '0);

  assign range_ok = (range_first_i != '0) && (range_first_i <= range_last_i) &&
                    (range_last_i <= PosW'(items_q));

  always_comb begin
    state_d      = state_q;
    is_query_d   = is_query_q;
    items_d      = items_q;
    nodes_d      = nodes_q;
    bit_d        = bit_q;
    data_d       = data_q;
    cur_d        = cur_q;
    acc_d        = acc_q;
    res_status_d = res_status_q;
    max_xor_d    = max_xor_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;

    root_we    = 1'b0;
    root_waddr = ItemW'(items_q + ItemW'(1));
    root_wdata = nodes_q + NodeW'(1);
    root_ra_a  = items_q;
    root_ra_b  = '0;

    node_we    = 1'b0;
    node_waddr = cur_q;
    node_wdata = ent_a;
    node_ra_a  = '0;
    node_ra_b  = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          data_d       = data_value_i[ValueBits-1:0];
          bit_d        = BitIdxW'(ValueBits - 1);
          acc_d        = '0;
          res_status_d = STATUS_OK;
          state_d      = ST_FIN;
          unique case (mode_i)
            MODE_APPEND: begin
              if (items_q >= ItemW'(MaxItems)) begin
                res_status_d = STATUS_FULL;
              end else begin
                // new root is written up front; walk reads the previous root
                root_we    = 1'b1;
                root_ra_a  = items_q;
                cur_d      = nodes_q + NodeW'(1);
                nodes_d    = nodes_q + NodeW'(ValueBits + 1);
                items_d    = items_q + ItemW'(1);
                is_query_d = 1'b0;
                state_d    = ST_ROOT;
              end
            end
            MODE_QUERY: begin
              if (range_ok) begin
                root_ra_a  = ItemW'(range_last_i);
                root_ra_b  = ItemW'(range_first_i - PosW'(1));
                is_query_d = 1'b1;
                state_d    = ST_ROOT;
              end else begin
                res_status_d = STATUS_RANGE;
              end
            end
            MODE_CLEAR: begin
              items_d = '0;
              nodes_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_ROOT: begin
        node_ra_a = root_a;
        node_ra_b = root_b;
        state_d   = ST_WALK;
      end
      ST_WALK: begin
        if (is_query_q) begin
          node_ra_a = (key_bit ^ take) ? ent_a.child_one : ent_a.child_zero;
          node_ra_b = (key_bit ^ take) ? ent_b.child_one : ent_b.child_zero;
          acc_d     = (acc_q << 1) | ValueBits'(take);
        end else begin
          // copy the previous node, point the key path at the fresh node
          node_we    = 1'b1;
          node_waddr = cur_q;
          node_wdata = ent_a;
          if (key_bit) begin
            node_wdata.child_one = fresh;
            node_wdata.count_one = ent_a.count_one + CntW'(1);
          end else begin
            node_wdata.child_zero = fresh;
            node_wdata.count_zero = ent_a.count_zero + CntW'(1);
          end
          node_ra_a = key_bit ? ent_a.child_one : ent_a.child_zero;
          cur_d     = fresh;
        end
        if (last_level) begin
          state_d = ST_FIN;
        end else begin
          bit_d = bit_q - BitIdxW'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          max_xor_d   = DataW'(acc_q);
          status_d    = res_status_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      is_query_q  <= 1'b0;
      items_q     <= '0;
      nodes_q     <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      is_query_q  <= is_query_d;
      items_q     <= items_d;
      nodes_q     <= nodes_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q       <= data_d;
    cur_q        <= cur_d;
    acc_q        <= acc_d;
    res_status_q <= res_status_d;
    max_xor_q    <= max_xor_d;
    status_q     <= status_d;
  end

  // Version root memory: one write, two reads
  always_ff @(posedge clk_i) begin
    if (root_we) begin
      root_mem[root_waddr] <= root_wdata;
    end
    root_rd_a_q   <= root_mem[root_ra_a];
    root_rd_b_q   <= root_mem[root_ra_b];
    root_null_a_q <= (root_ra_a == '0);
    root_null_b_q <= (root_ra_b == '0);
  end

  // Node memory: one write, two reads; appends never read nodes they write
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd_a_q   <= node_mem[node_ra_a];
    node_rd_b_q   <= node_mem[node_ra_b];
    node_null_a_q <= (node_ra_a == '0);
    node_null_b_q <= (node_ra_b == '0);
  end

endmodule

### bench/range_max_xor_trie_unit_tb.sv
`timescale 1ns / 1ps

module range_max_xor_trie_unit_tb;
  import rmxt_pkg::*;

  localparam int HalfPeriod  = 10;
  localparam int ResetCycles = 6;
  localparam int TotalItems  = 1100;
  localparam int HoldAt      = 300;
  localparam int FillAt      = 40;
  localparam int LongHold    = 400;
  localparam int DrainCycles = 60;
  localparam int CycleLimit  = 600000;

  // mode 3 has no operation behind it
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  // Persistent trie mirror plus the queue of answers still owed by the block.
  class trie_scoreboard;
    typedef struct packed {
      logic [DataW-1:0] max_xor;
      status_e          status;
    } answer_t;

    bit [NodeW-1:0] kid_zero    [NodeDepth];
    bit [NodeW-1:0] kid_one     [NodeDepth];
    bit [CntW-1:0]  hits        [NodeDepth];
    bit [NodeW-1:0] version_top [RootDepth];
    int unsigned    nodes_taken;
    int unsigned    items_held;
    answer_t        awaited [$];
    int unsigned    mismatches;
    int unsigned    results_seen;
    int unsigned    n_append, n_full, n_query, n_range, n_clear;

    task report(string what);
      mismatches++;
      $display("MISMATCH @%0t result %0d: %s", $time, results_seen, what);
    endtask

    // New version: fresh root and one fresh node per level, rest shared.
    function void add_value(logic [DataW-1:0] v);
      bit [NodeW-1:0] prev, cur, fresh, shared;
      int lvl;
      prev = version_top[items_held];
      nodes_taken++;
      cur = NodeW'(nodes_taken);
      version_top[items_held + 1] = cur;
      for (lvl = ValueBits - 1; lvl >= 0; lvl--) begin
        nodes_taken++;
        fresh = NodeW'(nodes_taken);
        if (v[lvl]) begin
          kid_one[cur]  = fresh;
          kid_zero[cur] = kid_zero[prev];
          shared        = kid_one[prev];
        end else begin
          kid_zero[cur] = fresh;
          kid_one[cur]  = kid_one[prev];
          shared        = kid_zero[prev];
        end
        hits[fresh] = hits[shared] + 1'b1;
        prev = shared;
        cur  = fresh;
      end
      items_held++;
    endfunction

    // Greedy walk: take the branch opposite the key bit when the range holds one.
    function logic [DataW-1:0] best_xor(bit [NodeW-1:0] older, bit [NodeW-1:0] newer,
                                        logic [DataW-1:0] key);
      logic [DataW-1:0] acc;
      bit [NodeW-1:0]   lo_far, hi_far;
      int               lvl;
      acc = '0;
      for (lvl = ValueBits - 1; lvl >= 0; lvl--) begin
        lo_far = key[lvl] ? kid_zero[older] : kid_one[older];
        hi_far = key[lvl] ? kid_zero[newer] : kid_one[newer];
        if (hits[hi_far] > hits[lo_far]) begin
          older = lo_far;
          newer = hi_far;
          acc   = {acc[DataW-2:0], 1'b1};
        end else begin
          older = key[lvl] ? kid_one[older] : kid_zero[older];
          newer = key[lvl] ? kid_one[newer] : kid_zero[newer];
          acc   = {acc[DataW-2:0], 1'b0};
        end
      end
      return acc;
    endfunction

    function void note_request(logic [ModeW-1:0] m, logic [DataW-1:0] v,
                               logic [PosW-1:0] f, logic [PosW-1:0] l);
      answer_t a;
      a.max_xor = '0;
      a.status  = STATUS_OK;
      case (m)
        MODE_APPEND: begin
          if (items_held >= MaxItems) begin
            a.status = STATUS_FULL;
            n_full++;
          end else begin
            add_value(v);
            n_append++;
          end
        end
        MODE_QUERY: begin
          n_query++;
          if (f >= 1 && f <= l && l <= items_held) begin
            a.max_xor = best_xor(version_top[f - 1'b1], version_top[l], v);
          end else begin
            a.status = STATUS_RANGE;
            n_range++;
          end
        end
        MODE_CLEAR: begin
          nodes_taken    = 0;
          items_held     = 0;
          version_top[0] = '0;
          n_clear++;
        end
        default: ;
      endcase
      awaited.insert(awaited.size(), a);
    endfunction

    task check_result(logic [DataW-1:0] got_xor, logic [StatusW-1:0] got_status);
      answer_t a;
      results_seen++;
      if (awaited.size() == 0) begin
        report($sformatf("result with no request pending: max_xor=%h status=%0d",
                         got_xor, got_status));
      end else begin
        a = awaited.pop_front();
        if (got_status !== a.status)
          report($sformatf("status %0d, expected %0d", got_status, a.status));
        if (got_xor !== a.max_xor)
          report($sformatf("max_xor %h, expected %h", got_xor, a.max_xor));
      end
    endtask
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [ModeW-1:0]   mode_i        = '0;
  logic [DataW-1:0]   data_value_i  = '0;
  logic [PosW-1:0]    range_first_i = '0;
  logic [PosW-1:0]    range_last_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [DataW-1:0]   max_xor_o;
  logic [StatusW-1:0] status_o;

  trie_scoreboard   sb;
  logic [DataW-1:0] history [$];
  bit               quiet        = 1'b0;
  bit               hold_pending = 1'b0;
  int unsigned      cycles       = 0;
  int unsigned      sent         = 0;

  range_max_xor_trie_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .data_value_i (data_value_i),
    .range_first_i(range_first_i),
    .range_last_i (range_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .max_xor_o    (max_xor_o),
    .status_o     (status_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(max_xor_o, status_o);
  end

  // Receiver: random stall bursts, one long hold-off on request from the sender.
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall = LongHold;
      end else if (stall == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 18);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(logic [ModeW-1:0] m, logic [DataW-1:0] v,
                              logic [PosW-1:0] f, logic [PosW-1:0] l);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    data_value_i  <= v;
    range_first_i <= f;
    range_last_i  <= l;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(m, v, f, l);
    sent++;
    if (sent == HoldAt) hold_pending = 1'b1;
    @(negedge clk_i);
  endtask

  // Mix of wide random values, small ones, extremes and near-copies of stored values.
  function automatic logic [DataW-1:0] pick_value();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = DataW'($urandom_range(0, 15));
      1: v = ($urandom_range(0, 1) != 0) ? '1 : '0;
      2: v = {4'($urandom_range(0, 15)), 28'($urandom)};
      3, 4: begin
        if (history.size() == 0) v = $urandom;
        else v = history[$urandom_range(0, history.size() - 1)] ^ (32'h1 << $urandom_range(0, 31));
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic do_append(logic [DataW-1:0] v);
    if (sb.items_held < MaxItems) history.insert(history.size(), v);
    send_request(MODE_APPEND, v, PosW'($urandom), PosW'($urandom));
  endtask

  task automatic do_clear();
    history.delete();
    send_request(MODE_CLEAR, $urandom, PosW'($urandom), PosW'($urandom));
  endtask

  task automatic random_query();
    int unsigned      held, f, l;
    logic [DataW-1:0] key;
    held = sb.items_held;
    key  = pick_value();
    if (held > 0 && $urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 3))
        0: begin
          f = 1;
          l = held;
        end
        1: begin
          f = $urandom_range(1, held);
          l = f;
        end
        default: begin
          f = $urandom_range(1, held);
          l = $urandom_range(f, held);
        end
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          f = 0;
          l = $urandom_range(0, 2047);
        end
        1: begin
          f = $urandom_range(2, 2047);
          l = $urandom_range(1, f - 1);
        end
        2: begin
          f = $urandom_range(1, held + 1);
          l = $urandom_range(held + 1, 2047);
        end
        default: begin
          f = $urandom_range(0, 2047);
          l = $urandom_range(0, 2047);
        end
      endcase
    end
    send_request(MODE_QUERY, key, PosW'(f), PosW'(l));
  endtask

  initial begin
    int unsigned seg_len;
    int unsigned pick;
    int unsigned k;
    bit          filled;
    sb = new();
    filled = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty store, extremes, every mode, every bad-range shape
    send_request(MODE_QUERY, 32'h0, 11'd1, 11'd1);
    do_append(32'h0000_0000);
    do_append(32'hFFFF_FFFF);
    do_append(32'h8000_0000);
    do_append(32'h7FFF_FFFF);
    do_append(32'h0F0F_0F0F);
    send_request(MODE_QUERY, 32'h0000_0000, 11'd1, 11'd5);
    send_request(MODE_QUERY, 32'hFFFF_FFFF, 11'd1, 11'd5);
    send_request(MODE_QUERY, 32'h1234_5678, 11'd2, 11'd2);
    send_request(MODE_QUERY, 32'h8000_0000, 11'd3, 11'd4);
    send_request(MODE_QUERY, 32'h0, 11'd0, 11'd1);
    send_request(MODE_QUERY, 32'h0, 11'd4, 11'd2);
    send_request(MODE_QUERY, 32'h0, 11'd1, 11'd6);
    send_request(MODE_QUERY, 32'hFFFF_FFFF, 11'd2047, 11'd2047);
    send_request(MODE_QUERY, 32'h0, 11'd1024, 11'd1024);
    send_request(ModeUnused, 32'hDEAD_BEEF, 11'd2047, 11'd2047);
    do_clear();
    send_request(MODE_QUERY, 32'h0, 11'd1, 11'd1);
    do_append(32'h5A5A_5A5A);
    send_request(MODE_QUERY, 32'hA5A5_A5A5, 11'd1, 11'd1);

    while (sent < TotalItems) begin
      if (!filled && sent >= FillAt) begin
        // fill to capacity, then hit the refusal and the top positions
        filled = 1'b1;
        do_clear();
        while (sb.items_held < MaxItems) begin
          do_append(pick_value());
          if ($urandom_range(0, 127) == 0) random_query();
        end
        do_append(pick_value());
        do_append(32'hFFFF_FFFF);
        send_request(MODE_QUERY, $urandom, PosW'(MaxItems), PosW'(MaxItems));
        send_request(MODE_QUERY, $urandom, 11'd1, PosW'(MaxItems));
        send_request(MODE_QUERY, 32'h0, 11'd1, PosW'(MaxItems));
        send_request(MODE_QUERY, 32'hFFFF_FFFF, PosW'(MaxItems), PosW'(MaxItems + 1));
        repeat (4) random_query();
        do_clear();
        // closing stretch runs without idle cycles
        quiet = 1'b1;
      end
      if ($urandom_range(0, 2) == 0) do_clear();
      seg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 20);
      for (k = 0; k < seg_len && sent < TotalItems; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) do_append(pick_value());
        else if (pick < 96) random_query();
        else if (pick < 98) send_request(ModeUnused, $urandom, PosW'($urandom), PosW'($urandom));
        else do_clear();
      end
    end
    in_valid_i <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("summary: %0d appends (%0d refused when full), %0d queries (%0d bad), %0d clears",
             sb.n_append, sb.n_full, sb.n_query, sb.n_range, sb.n_clear);
    $display("summary: %0d results compared, %0d mismatches, one long receiver hold-off",
             sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
